FILE: rtl/core/cpio_newc_stream_parser_top_macros.svh
// ----------------------------------------------------------------------------
// cpio newc parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef CPIO_NEWC_STREAM_PARSER_TOP_MACROS_SVH
`define CPIO_NEWC_STREAM_PARSER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPIO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CPIO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/cpio_pkg.sv
// ----------------------------------------------------------------------------
// cpio newc parser package
// Parser state, result flags, header layout constants and small decoders.
// ----------------------------------------------------------------------------
package cpio_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NAME    = 3'd1,
        PH_NAMEPAD = 3'd2,
        PH_DATA    = 3'd3,
        PH_DATAPAD = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_NAME   = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_PAD    = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;

    localparam logic [6:0] HDR_LAST  = 7'd109;
    localparam logic [6:0] FSZ_FIRST = 7'd54;
    localparam logic [6:0] FSZ_END   = 7'd62;
    localparam logic [6:0] NSZ_FIRST = 7'd94;
    localparam logic [6:0] NSZ_END   = 7'd102;

    localparam logic [3:0] TRL_LEN  = 4'd11;
    localparam logic [3:0] TRL_LAST = 4'd10;

    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UF = 8'h46;
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LF = 8'h66;

    typedef struct packed {
        phase_t      phase;
        logic [6:0]  hdr_pos;
        logic [31:0] name_acc;
        logic [31:0] file_acc;
        logic [31:0] remaining;
        logic [1:0]  align;
        logic [3:0]  name_idx;   // saturates at TRL_LEN
        logic        match;
        logic        digit_err;
        logic        finished;
    } state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       entry_start;
        logic       name_last;
        logic       data_last;
        logic       trailer_found;
    } flags_t;

    // Returns {not_hex, value}; a non-hex character decodes as zero.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            r = {1'b0, c[3:0]};
        end else if ((c >= CHAR_UA && c <= CHAR_UF) || (c >= CHAR_LA && c <= CHAR_LF)) begin
            r = {1'b0, 4'(c[3:0] + 4'd9)};
        end else begin
            r = 5'b10000;
        end
        return r;
    endfunction

    // Characters of the closing entry name, including its terminating zero.
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h54;
            4'd1:    ch = 8'h52;
            4'd2:    ch = 8'h41;
            4'd3:    ch = 8'h49;
            4'd4:    ch = 8'h4C;
            4'd5:    ch = 8'h45;
            4'd6:    ch = 8'h52;
            4'd7:    ch = 8'h21;
            4'd8:    ch = 8'h21;
            4'd9:    ch = 8'h21;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/core/cpio_step.sv
// ----------------------------------------------------------------------------
// cpio newc parser step logic
// Next parser state and result flags for one archive byte.
// ----------------------------------------------------------------------------
module cpio_step (
    input  cpio_pkg::state_t st,
    input  logic [7:0]       byte_in,
    output cpio_pkg::state_t st_next,
    output cpio_pkg::flags_t flags
);

    // Entry is over: either the archive ends or the next header begins.
    function automatic cpio_pkg::state_t end_entry(input cpio_pkg::state_t s);
        cpio_pkg::state_t r;
        r = s;
        if (s.match) begin
            r.finished = 1'b1;
            r.phase    = cpio_pkg::PH_DONE;
        end else begin
            r.phase   = cpio_pkg::PH_HEADER;
            r.hdr_pos = '0;
        end
        return r;
    endfunction

    function automatic cpio_pkg::state_t after_data(input cpio_pkg::state_t s);
        cpio_pkg::state_t r;
        r = s;
        if (s.align == 2'd0) begin
            r = end_entry(s);
        end else begin
            r.phase = cpio_pkg::PH_DATAPAD;
        end
        return r;
    endfunction

    function automatic cpio_pkg::state_t after_namepad(input cpio_pkg::state_t s);
        cpio_pkg::state_t r;
        r = s;
        if (s.file_acc == 32'd0) begin
            r = after_data(s);
        end else begin
            r.remaining = s.file_acc;
            r.phase     = cpio_pkg::PH_DATA;
        end
        return r;
    endfunction

    function automatic cpio_pkg::state_t after_name(input cpio_pkg::state_t s);
        cpio_pkg::state_t r;
        r = s;
        if (s.align == 2'd0) begin
            r = after_namepad(s);
        end else begin
            r.phase = cpio_pkg::PH_NAMEPAD;
        end
        return r;
    endfunction

    logic [4:0]  hex;
    logic [31:0] rem_dec;
    logic [1:0]  align_inc;
    logic        in_fsz;
    logic        in_nsz;
    cpio_pkg::state_t s;

    assign hex       = cpio_pkg::hex_decode(byte_in);
    assign rem_dec   = st.remaining - 32'd1;
    assign align_inc = st.align + 2'd1;
    assign in_fsz    = (st.hdr_pos >= cpio_pkg::FSZ_FIRST) && (st.hdr_pos < cpio_pkg::FSZ_END);
    assign in_nsz    = (st.hdr_pos >= cpio_pkg::NSZ_FIRST) && (st.hdr_pos < cpio_pkg::NSZ_END);

    always_comb begin
        s     = st;
        flags = '{kind: cpio_pkg::KIND_DONE, default: 1'b0};
        unique case (st.phase)
            cpio_pkg::PH_HEADER: begin
                flags.kind = cpio_pkg::KIND_HEADER;
                if (st.hdr_pos == 7'd0) begin
                    flags.entry_start = 1'b1;
                    s.name_acc  = '0;
                    s.file_acc  = '0;
                    s.digit_err = 1'b0;
                    s.match     = 1'b1;
                end
                if (in_fsz) begin
                    s.file_acc  = {s.file_acc[27:0], hex[3:0]};
                    s.digit_err = s.digit_err | hex[4];
                end
                if (in_nsz) begin
                    s.name_acc  = {s.name_acc[27:0], hex[3:0]};
                    s.digit_err = s.digit_err | hex[4];
                end
                s.align = align_inc;
                if (st.hdr_pos >= cpio_pkg::HDR_LAST) begin
                    s.hdr_pos   = '0;
                    s.remaining = s.name_acc;
                    if (s.name_acc == 32'd0) begin
                        s.match = 1'b0;
                        s = after_name(s);
                    end else begin
                        s.name_idx = '0;
                        s.phase    = cpio_pkg::PH_NAME;
                    end
                end else begin
                    s.hdr_pos = st.hdr_pos + 7'd1;
                end
            end
            cpio_pkg::PH_NAME: begin
                flags.kind = cpio_pkg::KIND_NAME;
                if (st.name_idx < cpio_pkg::TRL_LEN
                    && byte_in != cpio_pkg::trailer_char(st.name_idx)) begin
                    s.match = 1'b0;
                end
                if (st.name_idx < cpio_pkg::TRL_LEN) begin
                    s.name_idx = st.name_idx + 4'd1;
                end
                s.remaining = rem_dec;
                s.align     = align_inc;
                if (rem_dec == 32'd0) begin
                    flags.name_last     = 1'b1;
                    s.match             = s.match && (st.name_idx >= cpio_pkg::TRL_LAST);
                    flags.trailer_found = s.match;
                    s = after_name(s);
                end
            end
            cpio_pkg::PH_NAMEPAD: begin
                flags.kind = cpio_pkg::KIND_PAD;
                s.align    = align_inc;
                if (align_inc == 2'd0) begin
                    s = after_namepad(s);
                end
            end
            cpio_pkg::PH_DATA: begin
                flags.kind  = cpio_pkg::KIND_DATA;
                s.remaining = rem_dec;
                s.align     = align_inc;
                if (rem_dec == 32'd0) begin
                    flags.data_last = 1'b1;
                    s = after_data(s);
                end
            end
            cpio_pkg::PH_DATAPAD: begin
                flags.kind = cpio_pkg::KIND_PAD;
                s.align    = align_inc;
                if (align_inc == 2'd0) begin
                    s = end_entry(s);
                end
            end
            default: begin
                flags.kind = cpio_pkg::KIND_DONE;
                s.finished = 1'b1;
                s.phase    = cpio_pkg::PH_DONE;
            end
        endcase
        st_next = s;
    end

endmodule

FILE: rtl/core/cpio_newc_stream_parser_top.sv
// Path: an accepted byte waits in the input register and passes to the result register when
// the parser advances; its result transaction then completes when the result side takes it.
// Throughput: one byte per cycle, sustained while the result side keeps taking transactions.
// The rate rests on the combinational parser state update between input and result registers.
// Reset (aresetn low, synchronous) empties both registers and returns the parser to the start
// of an entry header with zeroed sizes and alignment; no clearing pass is needed.
// ----------------------------------------------------------------------------
// cpio newc stream parser, top level
// Classifies each byte of a newc archive and decodes the header size fields.
// ----------------------------------------------------------------------------
`include "cpio_newc_stream_parser_top_macros.svh"

module cpio_newc_stream_parser_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_archive_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_out,
    output logic [2:0]  m_byte_kind,
    output logic        m_entry_start,
    output logic        m_name_last,
    output logic        m_data_last,
    output logic [31:0] m_name_length,
    output logic [31:0] m_file_length,
    output logic        m_trailer_found,
    output logic        m_hex_error,
    output logic        m_archive_done
);

    // The input register holds one accepted byte until the parser can
    // process it. The parser advances exactly when that register is full and
    // the result register is empty or its transaction completes in the same
    // cycle, so a new byte is taken every cycle while the downstream side keeps pace.
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             advance;
    logic             s_fire;

    cpio_pkg::state_t state_reg;
    cpio_pkg::state_t state_next;
    cpio_pkg::flags_t flags;

    // Result payload registers; they carry no reset.
    logic [7:0]       byte_out_reg;
    cpio_pkg::flags_t flags_reg;
    logic [31:0]      name_len_reg;
    logic [31:0]      file_len_reg;
    logic             hex_err_reg;
    logic             done_reg;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // All per-byte decisions: phase walk, hex decode, trailer compare and
    // the four-byte alignment of name and data padding.
    cpio_step u_step (
        .st      (state_reg),
        .byte_in (in_byte_reg),
        .st_next (state_next),
        .flags   (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            state_reg.phase     <= cpio_pkg::PH_HEADER;
            state_reg.hdr_pos   <= '0;
            state_reg.name_acc  <= '0;
            state_reg.file_acc  <= '0;
            state_reg.remaining <= '0;
            state_reg.align     <= '0;
            state_reg.name_idx  <= '0;
            state_reg.match     <= 1'b1;
            state_reg.digit_err <= 1'b0;
            state_reg.finished  <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_archive_byte;
        end
        if (advance) begin
            byte_out_reg <= in_byte_reg;
            flags_reg    <= flags;
            name_len_reg <= state_next.name_acc;
            file_len_reg <= state_next.file_acc;
            hex_err_reg  <= state_next.digit_err;
            done_reg     <= state_next.finished;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_byte_out      = byte_out_reg;
    assign m_byte_kind     = flags_reg.kind;
    assign m_entry_start   = flags_reg.entry_start;
    assign m_name_last     = flags_reg.name_last;
    assign m_data_last     = flags_reg.data_last;
    assign m_name_length   = name_len_reg;
    assign m_file_length   = file_len_reg;
    assign m_trailer_found = flags_reg.trailer_found;
    assign m_hex_error     = hex_err_reg;
    assign m_archive_done  = done_reg;

    // Once the trailer entry is through, the parser never leaves that state.
    `CPIO_ASSERT_NEXT(a_done_sticky, aclk, aresetn, state_reg.finished, state_reg.finished)
    // An entry start is always reported on a header byte.
    `CPIO_ASSERT_NOW(a_start_on_header, aclk, aresetn, m_valid && m_entry_start,
        m_byte_kind == cpio_pkg::KIND_HEADER)
    // Bytes past the trailer come only with the archive marked complete.
    `CPIO_ASSERT_NOW(a_past_trailer_done, aclk, aresetn,
        m_valid && m_byte_kind == cpio_pkg::KIND_DONE, m_archive_done)
    // A held byte that cannot advance stays in the input register untouched.
    `CPIO_ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg))

endmodule
